### hw/rtl/modular_exponentiation_top_defines.svh
// ============================================================================
// Modular exponentiation assertion macros
// Shared property macros for the checker of the modular exponentiation block.
// ============================================================================
`ifndef MODULAR_EXPONENTIATION_TOP_DEFINES_SVH
`define MODULAR_EXPONENTIATION_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MEXP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MEXP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/mexp_pkg.sv
// ============================================================================
// Modular exponentiation package
// Widths, types and sequencer states shared by the modular exponentiation block.
// ============================================================================
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int OPERAND_WIDTH  = 32;
    localparam int EXPONENT_WIDTH = 32;
    localparam int FIELD_WIDTH    = 32;
    localparam int MUL_CNT_W      = $clog2(OPERAND_WIDTH);

    typedef logic [OPERAND_WIDTH-1:0]  operand_t;
    typedef logic [EXPONENT_WIDTH-1:0] exponent_t;
    typedef logic [FIELD_WIDTH-1:0]    field_t;

    localparam operand_t UNITY = operand_t'(1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_STEP,
        ST_MULT,
        ST_SQUARE,
        ST_FINISH
    } mexp_state_t;

    typedef struct packed {
        logic     start;
        operand_t multiplier;
        operand_t multiplicand;
    } mul_req_t;

    typedef struct packed {
        logic     busy;
        logic     done;
        operand_t product;
    } mul_rsp_t;

endpackage

### hw/rtl/mexp_channels.sv
// ============================================================================
// Modular exponentiation channels
// Valid/ready channels for operand items and result items.
// ============================================================================
`timescale 1ns / 1ps

interface mexp_req_if;
    logic                valid;
    logic                ready;
    mexp_pkg::field_t    base_value;
    mexp_pkg::field_t    exponent_value;
    mexp_pkg::field_t    modulus_value;

    modport source (output valid, output base_value, output exponent_value,
                    output modulus_value, input ready);
    modport sink   (input valid, input base_value, input exponent_value,
                    input modulus_value, output ready);
endinterface

interface mexp_rsp_if;
    logic                valid;
    logic                ready;
    mexp_pkg::field_t    power_result;
    logic                modulus_error;

    modport source (output valid, output power_result, output modulus_error, input ready);
    modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

### hw/rtl/mexp_mulmod.sv
// ============================================================================
// Modular multiplier
// Bit-serial interleaved multiply and reduce, one multiplier bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module mexp_mulmod
(
    input  logic                clk,
    input  logic                rst_n,
    input  mexp_pkg::mul_req_t  req,
    input  mexp_pkg::operand_t  modulus,
    output mexp_pkg::mul_rsp_t  rsp
);

    localparam int SW = mexp_pkg::OPERAND_WIDTH + 3;

    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;
    logic [mexp_pkg::MUL_CNT_W-1:0] cnt_reg, cnt_next;
    mexp_pkg::operand_t             a_reg, a_next;
    mexp_pkg::operand_t             b_reg, b_next;
    mexp_pkg::operand_t             r_reg, r_next;

    logic [SW-1:0]                  sum;
    logic [SW-1:0]                  diff1;
    logic [SW-1:0]                  diff2;
    mexp_pkg::operand_t             step;

    // The partial remainder stays below the modulus, so the sum stays below
    // three times the modulus and one of three candidates is the reduced value.
    always_comb
    begin
        sum   = {2'b00, r_reg, 1'b0}
              + (a_reg[mexp_pkg::OPERAND_WIDTH-1] ? {3'b000, b_reg} : '0);
        diff1 = sum - {3'b000, modulus};
        diff2 = sum - {2'b00, modulus, 1'b0};
        if (!diff2[SW-1])
        begin
            step = diff2[mexp_pkg::OPERAND_WIDTH-1:0];
        end
        else if (!diff1[SW-1])
        begin
            step = diff1[mexp_pkg::OPERAND_WIDTH-1:0];
        end
        else
        begin
            step = sum[mexp_pkg::OPERAND_WIDTH-1:0];
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        r_next    = r_reg;
        if (busy_reg)
        begin
            r_next = step;
            a_next = {a_reg[mexp_pkg::OPERAND_WIDTH-2:0], 1'b0};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
        else if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = mexp_pkg::MUL_CNT_W'(mexp_pkg::OPERAND_WIDTH - 1);
            a_next    = req.multiplier;
            b_next    = req.multiplicand;
            r_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

    assign rsp.busy    = busy_reg;
    assign rsp.done    = done_reg;
    assign rsp.product = r_reg;

endmodule

### hw/rtl/modular_exponentiation_top.sv
// ============================================================================
// Modular exponentiation top level
// Computes base to the exponent modulo modulus by right-to-left square and
// multiply over a shared bit-serial modular multiplier.
// ============================================================================
// Usage:
// The request channel carries a base, an exponent and a modulus in one
// transfer. The response channel returns the power and an error flag that
// is set, with a zero power, when the modulus is zero.
// Request ready is high only while the sequencer is idle, so one item is in
// work at a time. Each modular multiplication runs in the shared multiplier
// one multiplier bit per cycle, plus the hand-off.
// An item costs one multiplication to reduce the base, one squaring for each
// exponent bit below the highest set bit, one multiplication for each set bit
// and one pass through the step state for each exponent bit. Request ready
// returns high as the result is loaded into the output register. A zero
// modulus goes from the transfer straight to the finish state, and a zero
// exponent finishes after the base is reduced and the step state is passed.
// A finished result waits in an output register, and the next request is
// taken while it waits. If the receiver stalls, the following result holds
// in the sequencer until the output register frees up.
// Reset clears the sequencer and the output valid and drops any item in work.
// ============================================================================
`timescale 1ns / 1ps

module modular_exponentiation_top
(
    input  logic       clk,
    input  logic       rst_n,
    mexp_req_if.sink   request,
    mexp_rsp_if.source response
);

    mexp_pkg::mexp_state_t state_reg, state_next;
    mexp_pkg::operand_t    base_reg, base_next;
    mexp_pkg::operand_t    acc_reg, acc_next;
    mexp_pkg::operand_t    mod_reg, mod_next;
    mexp_pkg::exponent_t   exp_reg, exp_next;
    logic                  err_reg, err_next;

    logic                  out_valid_reg, out_valid_next;
    mexp_pkg::field_t      out_result_reg, out_result_next;
    logic                  out_error_reg, out_error_next;

    mexp_pkg::mul_req_t    mul_req;
    mexp_pkg::mul_rsp_t    mul_rsp;

    logic                  accept;
    logic                  out_free;
    mexp_pkg::operand_t    base_in;
    mexp_pkg::operand_t    mod_in;
    mexp_pkg::operand_t    unity_mod;

    mexp_mulmod u_mulmod
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mul_req),
        .modulus (mod_reg),
        .rsp     (mul_rsp)
    );

    assign request.ready = (state_reg == mexp_pkg::ST_IDLE);
    assign accept        = request.valid && request.ready;
    assign out_free      = !out_valid_reg || response.ready;
    assign base_in       = mexp_pkg::operand_t'(request.base_value);
    assign mod_in        = mexp_pkg::operand_t'(request.modulus_value);
    assign unity_mod     = (mod_in == mexp_pkg::UNITY) ? '0 : mexp_pkg::UNITY;

    always_comb
    begin
        state_next           = state_reg;
        base_next            = base_reg;
        acc_next             = acc_reg;
        mod_next             = mod_reg;
        exp_next             = exp_reg;
        err_next             = err_reg;
        out_valid_next       = out_valid_reg && !response.ready;
        out_result_next      = out_result_reg;
        out_error_next       = out_error_reg;
        mul_req.start        = 1'b0;
        mul_req.multiplier   = acc_reg;
        mul_req.multiplicand = base_reg;

        unique case (state_reg)
            mexp_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    base_next = base_in;
                    mod_next  = mod_in;
                    exp_next  = mexp_pkg::exponent_t'(request.exponent_value);
                    if (mod_in == '0)
                    begin
                        acc_next   = '0;
                        err_next   = 1'b1;
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        acc_next             = unity_mod;
                        err_next             = 1'b0;
                        mul_req.start        = 1'b1;
                        mul_req.multiplier   = base_in;
                        mul_req.multiplicand = unity_mod;
                        state_next           = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE:
            begin
                if (mul_rsp.done)
                begin
                    base_next  = mul_rsp.product;
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_STEP:
            begin
                if (exp_reg == '0)
                begin
                    state_next = mexp_pkg::ST_FINISH;
                end
                else if (exp_reg[0])
                begin
                    mul_req.start = 1'b1;
                    state_next    = mexp_pkg::ST_MULT;
                end
                else
                begin
                    mul_req.start        = 1'b1;
                    mul_req.multiplier   = base_reg;
                    mul_req.multiplicand = base_reg;
                    state_next           = mexp_pkg::ST_SQUARE;
                end
            end
            mexp_pkg::ST_MULT:
            begin
                if (mul_rsp.done)
                begin
                    acc_next = mul_rsp.product;
                    if ((exp_reg >> 1) == '0)
                    begin
                        state_next = mexp_pkg::ST_FINISH;
                    end
                    else
                    begin
                        mul_req.start        = 1'b1;
                        mul_req.multiplier   = base_reg;
                        mul_req.multiplicand = base_reg;
                        state_next           = mexp_pkg::ST_SQUARE;
                    end
                end
            end
            mexp_pkg::ST_SQUARE:
            begin
                if (mul_rsp.done)
                begin
                    base_next  = mul_rsp.product;
                    exp_next   = exp_reg >> 1;
                    state_next = mexp_pkg::ST_STEP;
                end
            end
            mexp_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_result_next = mexp_pkg::field_t'(acc_reg);
                    out_error_next  = err_reg;
                    state_next      = mexp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mexp_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg       <= base_next;
        acc_reg        <= acc_next;
        mod_reg        <= mod_next;
        exp_reg        <= exp_next;
        err_reg        <= err_next;
        out_result_reg <= out_result_next;
        out_error_reg  <= out_error_next;
    end

    assign response.valid         = out_valid_reg;
    assign response.power_result  = out_result_reg;
    assign response.modulus_error = out_error_reg;

endmodule

### hw/rtl/mexp_checker.sv
// ============================================================================
// Modular exponentiation checker
// Port-level properties of the modular exponentiation block, bound to its top.
// ============================================================================
`timescale 1ns / 1ps
`include "modular_exponentiation_top_defines.svh"

module mexp_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             req_valid,
    input logic             req_ready,
    input logic             rsp_valid,
    input logic             rsp_ready,
    input mexp_pkg::field_t rsp_result,
    input logic             rsp_error
);

    `MEXP_ASSERT_NEXT(a_busy_after_accept, req_valid && req_ready, !req_ready, "ready after accept")
    `MEXP_ASSERT_SAME(a_error_zero, rsp_valid && rsp_error, rsp_result == '0, "error with power")
    `MEXP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
    `MEXP_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_result), "result moved")

endmodule

bind modular_exponentiation_top mexp_checker u_mexp_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (request.valid),
    .req_ready  (request.ready),
    .rsp_valid  (response.valid),
    .rsp_ready  (response.ready),
    .rsp_result (response.power_result),
    .rsp_error  (response.modulus_error)
);

### tb/modular_exponentiation_top_tb.sv
// ============================================================================
// Modular exponentiation testbench
// Drives operand transfers into the modular exponentiation block and checks
// every result transfer against powers computed in the testbench. Directed
// corner cases come first, then random operands with random idle bursts on
// both channels, a long receiver hold-off and a full drain pause.
// ============================================================================
`timescale 1ns / 1ps

module modular_exponentiation_top_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_ITEMS = 268;
    localparam int QUIET_ITEMS  = 40;
    localparam int HOLD_CYCLES  = 3000;
    localparam int TAIL_CYCLES  = 2200;
    localparam int CYCLE_LIMIT  = 3000000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        mexp_pkg::field_t power;
        logic             error;
    } power_entry_t;

    class power_scoreboard;
        power_entry_t expected_powers[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        function power_entry_t modpow_expected(mexp_pkg::field_t base_in,
                                               mexp_pkg::field_t expo_in,
                                               mexp_pkg::field_t mod_in);
            power_entry_t         entry;
            logic [63:0]          acc;
            logic [63:0]          square;
            logic [63:0]          modulus;
            mexp_pkg::exponent_t  expo;
            modulus = 64'(mexp_pkg::operand_t'(mod_in));
            expo    = mexp_pkg::exponent_t'(expo_in);
            if (modulus == 64'd0)
            begin
                entry.power = '0;
                entry.error = 1'b1;
                return entry;
            end
            acc    = 64'(mexp_pkg::UNITY) % modulus;
            square = 64'(mexp_pkg::operand_t'(base_in)) % modulus;
            for (int i = 0; i < mexp_pkg::EXPONENT_WIDTH; i++)
            begin
                if (expo[i])
                    acc = (acc * square) % modulus;
                square = (square * square) % modulus;
            end
            entry.power = mexp_pkg::field_t'(acc);
            entry.error = 1'b0;
            return entry;
        endfunction

        function void note_request(mexp_pkg::field_t base_in, mexp_pkg::field_t expo_in,
                                   mexp_pkg::field_t mod_in);
            expected_powers.push_back(modpow_expected(base_in, expo_in, mod_in));
        endfunction

        function void check_response(mexp_pkg::field_t power, logic error);
            power_entry_t want;
            if (expected_powers.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: unexpected result power=%h error=%b", power, error);
                return;
            end
            want = expected_powers.pop_front();
            if (power !== want.power || error !== want.error)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("ERROR: expected power=%h error=%b, got power=%h error=%b",
                             want.power, want.error, power, error);
            end
        endfunction

        function int pending();
            return expected_powers.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   idle_on;
    bit   hold_output;
    int   cycle_count;

    power_scoreboard board = new();

    mexp_req_if req_if();
    mexp_rsp_if rsp_if();

    modular_exponentiation_top uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            board.check_response(rsp_if.power_result, rsp_if.modulus_error);
    end

    initial
    begin
        rsp_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_output)
            begin
                rsp_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_output = 1'b0;
                rsp_if.ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
                rsp_if.ready <= 1'b1;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    task automatic send_operands(mexp_pkg::field_t base_in, mexp_pkg::field_t expo_in,
                                 mexp_pkg::field_t mod_in);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            req_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        req_if.valid          <= 1'b1;
        req_if.base_value     <= base_in;
        req_if.exponent_value <= expo_in;
        req_if.modulus_value  <= mod_in;
        do
            @(posedge clk);
        while (!req_if.ready);
        board.note_request(base_in, expo_in, mod_in);
    endtask

    task automatic end_transfers();
        @(negedge clk);
        req_if.valid <= 1'b0;
    endtask

    task automatic wait_for_all_powers();
        while (board.pending() > 0)
            @(posedge clk);
    endtask

    function automatic mexp_pkg::field_t random_operand();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return mexp_pkg::field_t'($urandom_range(1, 16));
            3: return {1'b1, 31'($urandom)};
            default: return mexp_pkg::field_t'($urandom);
        endcase
    endfunction

    function automatic mexp_pkg::field_t random_exponent();
        int               bits;
        mexp_pkg::field_t mask;
        bits = ($urandom_range(0, 5) == 0) ? 32 : $urandom_range(1, 32);
        mask = (bits == 32) ? '1 : mexp_pkg::field_t'((64'd1 << bits) - 1);
        return mexp_pkg::field_t'($urandom) & mask;
    endfunction

    function automatic mexp_pkg::field_t random_modulus();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return mexp_pkg::field_t'(1);
            2: return '1;
            3: return mexp_pkg::field_t'($urandom_range(2, 16));
            4: return {1'b1, 31'($urandom)};
            default: return mexp_pkg::field_t'($urandom);
        endcase
    endfunction

    initial
    begin
        rst_n                 = 1'b0;
        idle_on               = 1'b0;
        hold_output           = 1'b0;
        cycle_count           = 0;
        req_if.valid          = 1'b0;
        req_if.base_value     = '0;
        req_if.exponent_value = '0;
        req_if.modulus_value  = '0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        send_operands(32'h1234_5678, 32'h0000_0005, 32'h0000_0000);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
        send_operands(32'h0000_0007, 32'h0000_0000, 32'h0000_000D);
        send_operands(32'h0000_0007, 32'h0000_0000, 32'h0000_0001);
        send_operands(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0000_0001);
        send_operands(32'h0000_0000, 32'h0000_0009, 32'h0000_0061);
        send_operands(32'h0000_0000, 32'h0000_0000, 32'h0000_0005);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_operands(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_operands(32'h0000_0003, 32'h8000_0000, 32'hFFFF_FFFB);
        send_operands(32'h0000_0002, 32'h0000_001F, 32'h8000_0000);
        send_operands(32'h0000_0064, 32'h0000_0003, 32'h0000_0007);
        send_operands(32'h0000_3039, 32'h0000_0001, 32'h0000_03E8);
        send_operands(32'h0000_0011, 32'h0000_0004, 32'h0000_0011);
        send_operands(32'hFFFF_FFFE, 32'h0000_0002, 32'h0000_0002);
        send_operands(32'h8000_0001, 32'h5555_5555, 32'hAAAA_AAAB);
        send_operands(32'h7FFF_FFFF, 32'hAAAA_AAAA, 32'h7FFF_FFFF);
        end_transfers();
        wait_for_all_powers();

        idle_on     = 1'b1;
        hold_output = 1'b1;
        for (int i = 0; i < 6; i++)
            send_operands(mexp_pkg::field_t'($urandom),
                          mexp_pkg::field_t'($urandom_range(1, 7)),
                          mexp_pkg::field_t'($urandom));

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
            begin
                end_transfers();
                wait_for_all_powers();
            end
            if (i == RANDOM_ITEMS - QUIET_ITEMS)
                idle_on = 1'b0;
            send_operands(random_operand(), random_exponent(), random_modulus());
        end
        end_transfers();

        wait_for_all_powers();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
